// ===== rtl/ray_sphere_intersect_unit_assert.svh =====
// Assertion macros for the ray-sphere intersection unit
`ifndef RAY_SPHERE_INTERSECT_UNIT_ASSERT_SVH
`define RAY_SPHERE_INTERSECT_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define RSI_CHECK(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// implication after a fixed number of cycles
`define RSI_CHECK_AFTER(label, pre, cycles, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> ##cycles (post)) \
      else $error(msg);

`endif

// ===== rtl/rsi_pkg.sv =====
// Types and constants shared by the ray-sphere intersection unit
`timescale 1ns / 1ps

package rsi_pkg;

   localparam int COORD_W      = 24;
   localparam int DIR_W        = 16;
   localparam int RADIUS_W     = 23;
   localparam int DIST_W       = 27;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int SQ_W         = 2 * COORD_W;
   localparam int CSQ_W        = SQ_W + 2;
   localparam int PROD_W       = DIFF_W + DIR_W;
   localparam int DOT_W        = PROD_W + 2;
   localparam int R2_W         = 2 * RADIUS_W;
   localparam int PROJ_W       = 32;
   localparam int DSQ_W        = 2 * PROJ_W - 2;
   localparam int RAD_W        = 64;
   localparam int ROOT_W       = RAD_W / 2;
   localparam int REM_W        = ROOT_W + 4;
   localparam int FRONT_STAGES = 5;
   localparam int LATENCY      = FRONT_STAGES + ROOT_W + 1;

   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_IDX_W    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_Z = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS   = 2'd3;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd4096;

   typedef struct packed {
      logic signed [COORD_W-1:0] centre_x;
      logic signed [COORD_W-1:0] centre_y;
      logic signed [COORD_W-1:0] centre_z;
      logic [RADIUS_W-1:0]       radius;
   } sphere_type;

   typedef struct packed {
      logic                     valid;
      logic                     miss;
      logic signed [PROJ_W-1:0] proj;
      logic [RAD_W-1:0]         rad;
      logic [REM_W-1:0]         rem;
      logic [ROOT_W-1:0]        root;
   } cell_type;

endpackage

// ===== rtl/rsi_csr.sv =====
// Sphere configuration registers behind the APB-style port
`timescale 1ns / 1ps

module rsi_csr import rsi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output sphere_type            sphere
);

   sphere_type               sphere_ff;
   sphere_type               sphere_in;
   logic [CSR_IDX_W-1:0]     index;
   logic                     wr_en;

   assign index = paddr[CSR_ADDR_W-1 -: CSR_IDX_W];
   assign wr_en = psel & penable & pwrite;

   always_comb begin
      sphere_in = sphere_ff;
      if (wr_en) begin
         case (index)
            CSR_CENTRE_X: sphere_in.centre_x = pwdata[COORD_W-1:0];
            CSR_CENTRE_Y: sphere_in.centre_y = pwdata[COORD_W-1:0];
            CSR_CENTRE_Z: sphere_in.centre_z = pwdata[COORD_W-1:0];
            CSR_RADIUS:   sphere_in.radius   = pwdata[RADIUS_W-1:0];
            default:      sphere_in = sphere_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sphere_ff.centre_x <= '0;
         sphere_ff.centre_y <= '0;
         sphere_ff.centre_z <= '0;
         sphere_ff.radius   <= RADIUS_RESET;
      end else begin
         sphere_ff <= sphere_in;
      end
   end

   always_comb begin
      case (index)
         CSR_CENTRE_X: prdata = CSR_DATA_W'(unsigned'(sphere_ff.centre_x));
         CSR_CENTRE_Y: prdata = CSR_DATA_W'(unsigned'(sphere_ff.centre_y));
         CSR_CENTRE_Z: prdata = CSR_DATA_W'(unsigned'(sphere_ff.centre_z));
         CSR_RADIUS:   prdata = CSR_DATA_W'(sphere_ff.radius);
         default:      prdata = '0;
      endcase
   end

   assign sphere = sphere_ff;

endmodule

// ===== rtl/rsi_front.sv =====
// Front pipeline: offset, squares, projection and discriminant
`timescale 1ns / 1ps

module rsi_front import rsi_pkg::*; #(
   parameter int DIR_FRAC_BITS = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [COORD_W-1:0] start_x,
   input  logic signed [COORD_W-1:0] start_y,
   input  logic signed [COORD_W-1:0] start_z,
   input  logic signed [DIR_W-1:0]   dir_x,
   input  logic signed [DIR_W-1:0]   dir_y,
   input  logic signed [DIR_W-1:0]   dir_z,
   input  sphere_type                sphere,
   output cell_type                  head
);

   localparam logic signed [DOT_W-1:0] PROJ_HI =
      {{(DOT_W-PROJ_W+1){1'b0}}, {(PROJ_W-1){1'b1}}};
   localparam logic signed [DOT_W-1:0] PROJ_LO = -PROJ_HI;

   // stage 1: offset to centre
   logic                     s1_valid_ff;
   logic signed [DIFF_W-1:0] s1_cx_ff, s1_cy_ff, s1_cz_ff;
   logic signed [DIFF_W-1:0] s1_cx_in, s1_cy_in, s1_cz_in;
   logic signed [DIR_W-1:0]  s1_dx_ff, s1_dy_ff, s1_dz_ff;
   logic [RADIUS_W-1:0]      s1_r_ff;

   assign s1_cx_in = DIFF_W'(sphere.centre_x) - DIFF_W'(start_x);
   assign s1_cy_in = DIFF_W'(sphere.centre_y) - DIFF_W'(start_y);
   assign s1_cz_in = DIFF_W'(sphere.centre_z) - DIFF_W'(start_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      s1_cx_ff <= s1_cx_in;
      s1_cy_ff <= s1_cy_in;
      s1_cz_ff <= s1_cz_in;
      s1_dx_ff <= dir_x;
      s1_dy_ff <= dir_y;
      s1_dz_ff <= dir_z;
      s1_r_ff  <= sphere.radius;
   end

   // stage 2: products
   logic                      s2_valid_ff;
   logic signed [2*DIFF_W-1:0] s2_sqx_in, s2_sqy_in, s2_sqz_in;
   logic [SQ_W-1:0]           s2_sqx_ff, s2_sqy_ff, s2_sqz_ff;
   logic signed [PROD_W-1:0]  s2_px_in, s2_py_in, s2_pz_in;
   logic signed [PROD_W-1:0]  s2_px_ff, s2_py_ff, s2_pz_ff;
   logic [R2_W-1:0]           s2_r2_in, s2_r2_ff;

   assign s2_sqx_in = s1_cx_ff * s1_cx_ff;
   assign s2_sqy_in = s1_cy_ff * s1_cy_ff;
   assign s2_sqz_in = s1_cz_ff * s1_cz_ff;
   assign s2_px_in  = PROD_W'(s1_dx_ff) * PROD_W'(s1_cx_ff);
   assign s2_py_in  = PROD_W'(s1_dy_ff) * PROD_W'(s1_cy_ff);
   assign s2_pz_in  = PROD_W'(s1_dz_ff) * PROD_W'(s1_cz_ff);
   assign s2_r2_in  = R2_W'(s1_r_ff) * R2_W'(s1_r_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_sqx_ff <= s2_sqx_in[SQ_W-1:0];
      s2_sqy_ff <= s2_sqy_in[SQ_W-1:0];
      s2_sqz_ff <= s2_sqz_in[SQ_W-1:0];
      s2_px_ff  <= s2_px_in;
      s2_py_ff  <= s2_py_in;
      s2_pz_ff  <= s2_pz_in;
      s2_r2_ff  <= s2_r2_in;
   end

   // stage 3: sums, floor shift and clamp of the projection
   logic                     s3_valid_ff;
   logic [CSQ_W-1:0]         s3_csq_in, s3_csq_ff;
   logic signed [DOT_W-1:0]  s3_dot, s3_shift;
   logic signed [PROJ_W-1:0] s3_proj_in, s3_proj_ff;
   logic [R2_W-1:0]          s3_r2_ff;

   assign s3_csq_in = CSQ_W'(s2_sqx_ff) + CSQ_W'(s2_sqy_ff) + CSQ_W'(s2_sqz_ff);
   assign s3_dot    = DOT_W'(s2_px_ff) + DOT_W'(s2_py_ff) + DOT_W'(s2_pz_ff);
   assign s3_shift  = s3_dot >>> DIR_FRAC_BITS;

   always_comb begin
      if (s3_shift > PROJ_HI) begin
         s3_proj_in = PROJ_HI[PROJ_W-1:0];
      end else if (s3_shift < PROJ_LO) begin
         s3_proj_in = PROJ_LO[PROJ_W-1:0];
      end else begin
         s3_proj_in = s3_shift[PROJ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_csq_ff  <= s3_csq_in;
      s3_proj_ff <= s3_proj_in;
      s3_r2_ff   <= s2_r2_ff;
   end

   // stage 4: square of the projection
   logic                       s4_valid_ff;
   logic signed [2*PROJ_W-1:0] s4_dsq_in;
   logic [DSQ_W-1:0]           s4_dsq_ff;
   logic [CSQ_W-1:0]           s4_csq_ff;
   logic signed [PROJ_W-1:0]   s4_proj_ff;
   logic [R2_W-1:0]            s4_r2_ff;

   assign s4_dsq_in = s3_proj_ff * s3_proj_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_dsq_ff  <= s4_dsq_in[DSQ_W-1:0];
      s4_csq_ff  <= s3_csq_ff;
      s4_proj_ff <= s3_proj_ff;
      s4_r2_ff   <= s3_r2_ff;
   end

   // stage 5: discriminant, head of the root chain
   logic [RAD_W-1:0] disc;
   cell_type         head_in, head_ff;

   assign disc = RAD_W'(s4_r2_ff) + RAD_W'(s4_dsq_ff) - RAD_W'(s4_csq_ff);

   always_comb begin
      head_in.valid = s4_valid_ff;
      head_in.miss  = disc[RAD_W-1];
      head_in.proj  = s4_proj_ff;
      head_in.rad   = disc[RAD_W-1] ? '0 : disc;
      head_in.rem   = '0;
      head_in.root  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else begin
         head_ff <= head_in;
      end
   end

   assign head = head_ff;

endmodule

// ===== rtl/rsi_sqrt_cell.sv =====
// One cell of the square-root chain: settles one root bit per cycle
`timescale 1ns / 1ps

module rsi_sqrt_cell import rsi_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cell_type cell_prev,
   output cell_type cell_next
);

   cell_type         cell_in, cell_ff;
   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] trial;
   logic             take;

   assign rem_sh = {cell_prev.rem[REM_W-3:0], cell_prev.rad[RAD_W-1 -: 2]};
   assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, cell_prev.root, 2'b01};
   assign take   = rem_sh >= trial;

   always_comb begin
      cell_in      = cell_prev;
      cell_in.rad  = {cell_prev.rad[RAD_W-3:0], 2'b00};
      cell_in.rem  = take ? rem_sh - trial : rem_sh;
      cell_in.root = {cell_prev.root[ROOT_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_next = cell_ff;

endmodule

// ===== rtl/ray_sphere_intersect_unit.sv =====
// Top level of the ray-sphere intersection unit
//
//   channel   ports                       handshake
//   request   start, busy, req_*          taken when start & !busy
//   result    rsp_valid, rsp_*            one-cycle strobe, no backpressure
//   config    psel/penable/pwrite/paddr   APB write, pready tied high
//
// The pipeline has five arithmetic stages, a 32-cell square-root chain
// settling one root bit per cell, and one output register.
// One request per cycle; busy stays low, the pipeline never stalls.
// Synchronous reset clears every valid flag and loads the reset sphere.
`timescale 1ns / 1ps

`include "ray_sphere_intersect_unit_assert.svh"

module ray_sphere_intersect_unit import rsi_pkg::*; #(
   parameter int DIR_FRAC_BITS = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_start_x,
   input  logic signed [COORD_W-1:0] req_start_y,
   input  logic signed [COORD_W-1:0] req_start_z,
   input  logic signed [DIR_W-1:0]   req_dir_x,
   input  logic signed [DIR_W-1:0]   req_dir_y,
   input  logic signed [DIR_W-1:0]   req_dir_z,
   output logic                      rsp_valid,
   output logic                      rsp_hit,
   output logic                      rsp_from_inside,
   output logic [DIST_W-1:0]         rsp_distance,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   output logic [CSR_DATA_W-1:0]     prdata,
   output logic                      pready
);

   sphere_type sphere;
   cell_type   chain [0:ROOT_W];

   assign busy   = 1'b0;
   assign pready = 1'b1;

   rsi_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .sphere  (sphere)
   );

   rsi_front #(
      .DIR_FRAC_BITS (DIR_FRAC_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .start_x (req_start_x),
      .start_y (req_start_y),
      .start_z (req_start_z),
      .dir_x   (req_dir_x),
      .dir_y   (req_dir_y),
      .dir_z   (req_dir_z),
      .sphere  (sphere),
      .head    (chain[0])
   );

   for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
      rsi_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_prev (chain[i]),
         .cell_next (chain[i+1])
      );
   end

   // pick the nearer root ahead of the start point
   logic [PROJ_W+1:0] far_root, near_root, dist_sel;
   logic              far_neg, near_neg;
   logic              hit_in, inside_in;
   logic [DIST_W-1:0] dist_in;

   logic              rsp_valid_ff;
   logic              rsp_hit_ff, rsp_inside_ff;
   logic [DIST_W-1:0] rsp_dist_ff;

   assign far_root  = (PROJ_W+2)'(chain[ROOT_W].proj) + (PROJ_W+2)'(chain[ROOT_W].root);
   assign near_root = (PROJ_W+2)'(chain[ROOT_W].proj) - (PROJ_W+2)'(chain[ROOT_W].root);
   assign far_neg   = far_root[PROJ_W+1];
   assign near_neg  = near_root[PROJ_W+1];
   assign hit_in    = !chain[ROOT_W].miss && !far_neg;
   assign inside_in = hit_in && near_neg;
   assign dist_sel  = near_neg ? far_root : near_root;

   always_comb begin
      if (!hit_in) begin
         dist_in = '0;
      end else if (|dist_sel[PROJ_W+1:DIST_W]) begin
         dist_in = '1;
      end else begin
         dist_in = dist_sel[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= chain[ROOT_W].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff    <= hit_in;
      rsp_inside_ff <= inside_in;
      rsp_dist_ff   <= dist_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_from_inside = rsp_inside_ff;
   assign rsp_distance    = rsp_dist_ff;

   `RSI_CHECK_AFTER(a_latency, start && !busy, LATENCY, rsp_valid, "request lost in pipeline")
   `RSI_CHECK(a_inside_hit, rsp_valid && rsp_from_inside, rsp_hit, "inside flag without hit")
   `RSI_CHECK(a_miss_zero, rsp_valid && !rsp_hit, rsp_distance == '0, "miss with distance")

endmodule
